FILE: src/ialu_pkg.sv
// ----------------------------------------------------------------------------
// ialu_pkg
// shared types and constants for the pipelined 64-bit integer alu
// ----------------------------------------------------------------------------
package ialu_pkg;

    localparam int unsigned DataWidth = 64;
    localparam int unsigned HalfWidth = DataWidth / 2;
    localparam int unsigned ModeWidth = 4;

    typedef enum logic [ModeWidth-1:0] {
        OP_ADD    = 4'd0,
        OP_SUB    = 4'd1,
        OP_MUL    = 4'd2,
        OP_DIV    = 4'd3,
        OP_MOD    = 4'd4,
        OP_AND    = 4'd5,
        OP_OR     = 4'd6,
        OP_XOR    = 4'd7,
        OP_SHL    = 4'd8,
        OP_SHR    = 4'd9,
        OP_NEG    = 4'd10,
        OP_NOT    = 4'd11,
        OP_BITNOT = 4'd12
    } alu_op_t;

    // payload that travels down the pipe next to its valid bit
    typedef struct packed {
        logic [ModeWidth-1:0] mode;
        logic                 a_neg;
        logic                 b_neg;
        logic                 ok;
        logic [DataWidth-1:0] res;
        logic [DataWidth-1:0] pp_lo;
        logic [HalfWidth-1:0] pp_cross;
        logic [DataWidth-1:0] rem;
        logic [DataWidth-1:0] quo;
        logic [DataWidth-1:0] dvs;
    } pipe_t;

    function automatic logic [DataWidth-1:0] mag(input logic [DataWidth-1:0] x);
        mag = x[DataWidth-1] ? (~x + 1'b1) : x;
    endfunction

endpackage

FILE: src/ialu_mul.sv
// ----------------------------------------------------------------------------
// ialu_mul
// partial products for the low half of a 64 x 64 product
// ----------------------------------------------------------------------------
module ialu_mul (
    input  logic [ialu_pkg::DataWidth-1:0] a,
    input  logic [ialu_pkg::DataWidth-1:0] b,
    output logic [ialu_pkg::DataWidth-1:0] pp_lo,
    output logic [ialu_pkg::HalfWidth-1:0] pp_cross
);

    localparam int unsigned H = ialu_pkg::HalfWidth;

    logic [2*H-1:0] p_ll;
    logic [2*H-1:0] p_lh;
    logic [2*H-1:0] p_hl;

    assign p_ll = a[H-1:0] * b[H-1:0];
    assign p_lh = a[H-1:0] * b[2*H-1:H];
    assign p_hl = a[2*H-1:H] * b[H-1:0];

    assign pp_lo    = p_ll;
    // only the low half of the cross terms reaches the low 64 bits
    assign pp_cross = p_lh[H-1:0] + p_hl[H-1:0];

endmodule

FILE: src/ialu_div_stage.sv
// ----------------------------------------------------------------------------
// ialu_div_stage
// one restoring division step, one quotient bit, registered
// ----------------------------------------------------------------------------
module ialu_div_stage (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              in_valid,
    input  ialu_pkg::pipe_t   in_data,
    output logic              out_valid,
    output ialu_pkg::pipe_t   out_data
);

    localparam int unsigned W = ialu_pkg::DataWidth;

    logic            valid_reg;
    ialu_pkg::pipe_t data_reg;
    ialu_pkg::pipe_t data_next;
    logic [W:0]      trial;
    logic [W:0]      diff;

    always_comb
    begin
        data_next = in_data;
        trial     = {in_data.rem, in_data.quo[W-1]};
        diff      = trial - {1'b0, in_data.dvs};
        if (!diff[W])
        begin
            data_next.rem = diff[W-1:0];
            data_next.quo = {in_data.quo[W-2:0], 1'b1};
        end
        else
        begin
            data_next.rem = trial[W-1:0];
            data_next.quo = {in_data.quo[W-2:0], 1'b0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

FILE: src/integer_alu_with_fold_valid.sv
// ----------------------------------------------------------------------------
// integer_alu_with_fold_valid
// signed 64-bit alu with fold valid flag, deep pipeline with bit-serial divider
// ----------------------------------------------------------------------------
// channel | dir | tdata                                 | tuser
// s_axis  | in  | [63:0] left_value, [127:64] right_value | [3:0] mode
// m_axis  | out | [63:0] result_value                   | [0] fold_valid
//
// one transaction per cycle while the output is not stalled; input register,
// decode stage, 64 divider steps of one quotient bit each, output register
// every operation walks the full divider pipe so results leave in order
// the whole pipe advances when the output register is empty or being taken
// reset clears only the valid bits
// ----------------------------------------------------------------------------
module integer_alu_with_fold_valid (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [127:0] s_tdata,   // left_value, right_value
    input  logic [3:0]   s_tuser,   // mode
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [63:0]  m_tdata,   // result_value
    output logic         m_tuser    // fold_valid
);

    localparam int unsigned W = ialu_pkg::DataWidth;
    localparam int unsigned H = ialu_pkg::HalfWidth;

    logic                            en;
    logic                            in_valid_reg;
    logic [ialu_pkg::ModeWidth-1:0]  mode_reg;
    logic [W-1:0]                    a_reg;
    logic [W-1:0]                    b_reg;
    ialu_pkg::pipe_t                 dec_next;
    logic [W-1:0]                    pp_lo;
    logic [H-1:0]                    pp_cross;
    logic                            stage_valid [0:W];
    ialu_pkg::pipe_t                 stage_data  [0:W];
    logic                            out_valid_reg;
    logic [W-1:0]                    out_data_reg;
    logic                            out_ok_reg;
    logic [W-1:0]                    out_data_next;
    logic                            out_ok_next;
    ialu_pkg::pipe_t                 fin;

    assign en       = !out_valid_reg || m_tready;
    assign s_tready = en;

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mode_reg <= s_tuser;
            a_reg    <= s_tdata[W-1:0];
            b_reg    <= s_tdata[2*W-1:W];
        end
    end

    ialu_mul u_mul (
        .a        (a_reg),
        .b        (b_reg),
        .pp_lo    (pp_lo),
        .pp_cross (pp_cross)
    );

    // decode stage: simple ops, magnitudes for the divider
    always_comb
    begin
        dec_next          = '0;
        dec_next.mode     = mode_reg;
        dec_next.a_neg    = a_reg[W-1];
        dec_next.b_neg    = b_reg[W-1];
        dec_next.ok       = 1'b1;
        dec_next.pp_lo    = pp_lo;
        dec_next.pp_cross = pp_cross;
        dec_next.rem      = '0;
        dec_next.quo      = ialu_pkg::mag(a_reg);
        dec_next.dvs      = ialu_pkg::mag(b_reg);
        unique case (ialu_pkg::alu_op_t'(mode_reg))
            ialu_pkg::OP_ADD:    dec_next.res = a_reg + b_reg;
            ialu_pkg::OP_SUB:    dec_next.res = a_reg - b_reg;
            ialu_pkg::OP_AND:    dec_next.res = a_reg & b_reg;
            ialu_pkg::OP_OR:     dec_next.res = a_reg | b_reg;
            ialu_pkg::OP_XOR:    dec_next.res = a_reg ^ b_reg;
            ialu_pkg::OP_NEG:    dec_next.res = ~a_reg + 1'b1;
            ialu_pkg::OP_NOT:    dec_next.res = {{(W-1){1'b0}}, (a_reg == '0)};
            ialu_pkg::OP_BITNOT: dec_next.res = ~a_reg;
            ialu_pkg::OP_MUL:    dec_next.res = '0;
            ialu_pkg::OP_DIV, ialu_pkg::OP_MOD:
            begin
                dec_next.ok = (b_reg != '0);
            end
            ialu_pkg::OP_SHL, ialu_pkg::OP_SHR:
            begin
                dec_next.ok = (b_reg[W-1:6] == '0);
                if (mode_reg == ialu_pkg::OP_SHL)
                    dec_next.res = a_reg << b_reg[5:0];
                else
                    dec_next.res = W'($signed(a_reg) >>> b_reg[5:0]);
            end
            default:             dec_next.ok = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid[0] <= 1'b0;
        end
        else if (en)
        begin
            stage_valid[0] <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            stage_data[0] <= dec_next;
        end
    end

    for (genvar i = 0; i < W; i++)
    begin : g_div
        ialu_div_stage u_stage (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .in_valid  (stage_valid[i]),
            .in_data   (stage_data[i]),
            .out_valid (stage_valid[i+1]),
            .out_data  (stage_data[i+1])
        );
    end

    // final select
    always_comb
    begin
        fin           = stage_data[W];
        out_ok_next   = fin.ok;
        out_data_next = fin.res;
        case (ialu_pkg::alu_op_t'(fin.mode))
            ialu_pkg::OP_MUL: out_data_next = fin.pp_lo + {fin.pp_cross, {H{1'b0}}};
            ialu_pkg::OP_DIV:
                out_data_next = (fin.a_neg ^ fin.b_neg) ? (~fin.quo + 1'b1) : fin.quo;
            ialu_pkg::OP_MOD: out_data_next = fin.a_neg ? (~fin.rem + 1'b1) : fin.rem;
            default:          out_data_next = fin.res;
        endcase
        if (!out_ok_next)
            out_data_next = '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= stage_valid[W];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_data_reg <= out_data_next;
            out_ok_reg   <= out_ok_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_ok_reg;

    a_zero_when_unfolded : assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser |-> m_tdata == '0)
        else $error("unfolded result carries nonzero data");

    a_ready_follows_output : assert property (@(posedge clk) disable iff (!rst_n)
        s_tready == (!m_tvalid || m_tready))
        else $error("input ready does not track output stage");

    a_stall_holds_pipe : assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> $stable(stage_valid[W]) && $stable(in_valid_reg))
        else $error("pipe moved during stall");

endmodule

FILE: tb/sv/alu_fold_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// alu_fold_checker
// watches both streams of the alu, predicts each folded result and compares
// ----------------------------------------------------------------------------
module alu_fold_checker
    import ialu_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    input  logic         s_tready,
    input  logic [127:0] s_tdata,
    input  logic [3:0]   s_tuser,
    input  logic         m_tvalid,
    input  logic         m_tready,
    input  logic [63:0]  m_tdata,
    input  logic         m_tuser,
    output int           error_count,
    output int           pending
);

    typedef struct packed {
        logic [63:0] value;
        logic        ok;
    } fold_t;

    fold_t expected_folds[$];

    function automatic logic [63:0] magnitude(input logic [63:0] x);
        return x[63] ? (64'd0 - x) : x;
    endfunction

    function automatic fold_t fold_op(input logic [3:0] mode, input logic [63:0] a,
                                      input logic [63:0] b);
        fold_t f;
        logic [63:0] q;
        f.ok = 1'b1;
        f.value = '0;
        case (mode)
            OP_ADD:    f.value = a + b;
            OP_SUB:    f.value = a - b;
            OP_MUL:    f.value = a * b;
            OP_DIV, OP_MOD:
            begin
                if (b == 64'd0)
                begin
                    f.ok = 1'b0;
                end
                else if (mode == OP_DIV)
                begin
                    q = magnitude(a) / magnitude(b);
                    f.value = (a[63] != b[63]) ? (64'd0 - q) : q;
                end
                else
                begin
                    q = magnitude(a) % magnitude(b);
                    f.value = a[63] ? (64'd0 - q) : q;
                end
            end
            OP_AND:    f.value = a & b;
            OP_OR:     f.value = a | b;
            OP_XOR:    f.value = a ^ b;
            OP_SHL:    if (b > 64'd63) f.ok = 1'b0; else f.value = a << b[5:0];
            OP_SHR:    if (b > 64'd63) f.ok = 1'b0; else f.value = $signed(a) >>> b[5:0];
            OP_NEG:    f.value = 64'd0 - a;
            OP_NOT:    f.value = (a == 64'd0) ? 64'd1 : 64'd0;
            OP_BITNOT: f.value = ~a;
            default:   f.ok = 1'b0;
        endcase
        if (!f.ok)
            f.value = '0;
        return f;
    endfunction

    task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
        $display("mismatch at %0t: %s got %h expected %h", $realtime, what, got, want);
        error_count++;
    endtask

    initial
    begin
        error_count = 0;
    end

    assign pending = expected_folds.size();

    always @(posedge clk)
    begin
        fold_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_folds.size() == 0)
            begin
                report("unexpected transaction", m_tdata, 64'd0);
            end
            else
            begin
                want = expected_folds.pop_front();
                if (m_tdata !== want.value)
                    report("result_value", m_tdata, want.value);
                if (m_tuser !== want.ok)
                    report("fold_valid", {63'd0, m_tuser}, {63'd0, want.ok});
            end
        end
        if (rst_n && s_tvalid && s_tready)
            expected_folds.push_back(fold_op(s_tuser, s_tdata[63:0], s_tdata[127:64]));
    end

endmodule

FILE: tb/sv/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// stimulus for the 64-bit folding alu: directed corners, then random
// operations with random idling on both streams and a long output stall
// ----------------------------------------------------------------------------
module tb;
    import ialu_pkg::*;

    localparam int PipeLatency = 67;
    localparam int CycleLimit  = 200000;

    logic         clk;
    logic         rst_n;
    logic         s_tvalid;
    logic         s_tready;
    logic [127:0] s_tdata;    // left_value, right_value
    logic [3:0]   s_tuser;    // mode
    logic         m_tvalid;
    logic         m_tready;
    logic [63:0]  m_tdata;    // result_value
    logic         m_tuser;    // fold_valid
    int           error_count;
    int           pending;
    int           cycle_count;
    bit           long_stall;

    localparam logic [63:0] MinVal = 64'h8000_0000_0000_0000;
    localparam logic [63:0] MaxVal = 64'h7fff_ffff_ffff_ffff;
    localparam logic [63:0] MinusOne = '1;

    integer_alu_with_fold_valid u_top (.*);

    alu_fold_checker u_checker (.*);

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        cycle_count = 0;
        forever
        begin
            @(posedge clk);
            cycle_count++;
            if (cycle_count > CycleLimit)
            begin
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    function automatic logic [63:0] rand64();
        logic [63:0] v;
        v = {$urandom, $urandom};
        case ($urandom_range(0, 7))
            0: v = MinVal;
            1: v = MaxVal;
            2: v = MinusOne;
            3: v = 64'd0;
            4: v = 64'($urandom_range(0, 70));
            5: v = 64'd0 - 64'($urandom_range(1, 70));
            default: ;
        endcase
        return v;
    endfunction

    task automatic send(input logic [3:0] mode, input logic [63:0] a, input logic [63:0] b);
        int gap;
        gap = $urandom_range(0, 3);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= mode;
        s_tdata  <= {b, a};
        do @(posedge clk); while (!s_tready);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
    endtask

    // receiver: random idling, plus one long hold-off on request
    initial
    begin
        int wait_n;
        m_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (long_stall)
            begin
                m_tready <= 1'b0;
                repeat (300) @(posedge clk);
                long_stall = 1'b0;
            end
            wait_n = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 3);
            if (wait_n > 0)
            begin
                m_tready <= 1'b0;
                repeat (wait_n) @(posedge clk);
            end
            m_tready <= 1'b1;
            @(posedge clk);
        end
    end

    initial
    begin
        logic [3:0] op;
        logic [63:0] a;
        logic [63:0] b;
        rst_n      = 1'b0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        s_tuser    = '0;
        long_stall = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed corners
        send(OP_ADD, MaxVal, 64'd1);
        send(OP_SUB, MinVal, 64'd1);
        send(OP_MUL, MaxVal, MaxVal);
        send(OP_DIV, 64'd0 - 64'd7, 64'd2);
        send(OP_MOD, 64'd0 - 64'd7, 64'd2);
        send(OP_DIV, 64'd7, 64'd0);
        send(OP_MOD, 64'd7, 64'd0);
        send(OP_DIV, MinVal, MinusOne);
        send(OP_MOD, MinVal, MinusOne);
        send(OP_DIV, MinVal, MinVal);
        send(OP_AND, MinusOne, 64'h5555_aaaa_5555_aaaa);
        send(OP_OR, 64'd0, 64'h5555_aaaa_5555_aaaa);
        send(OP_XOR, MinusOne, MinusOne);
        send(OP_SHL, 64'd1, 64'd63);
        send(OP_SHL, 64'd1, 64'd64);
        send(OP_SHR, MinVal, 64'd63);
        send(OP_SHR, MinVal, MinusOne);
        send(OP_NEG, MinVal, 64'd0);
        send(OP_NOT, 64'd0, 64'd5);
        send(OP_NOT, MinVal, 64'd0);
        send(OP_BITNOT, 64'd0, MinusOne);
        send(4'd13, MinusOne, MinusOne);
        send(4'd14, 64'd1, 64'd1);
        send(4'd15, 64'd1, 64'd1);
        // sender pauses until the pipe is empty
        drain();

        for (int i = 0; i < 700; i++)
        begin
            if (i == 200)
                long_stall = 1'b1;
            if (i == 450)
                drain();
            op = ($urandom_range(0, 19) == 0) ? 4'($urandom_range(13, 15))
                                               : 4'($urandom_range(0, 12));
            a = rand64();
            b = rand64();
            send(op, a, b);
        end
        drain();
        repeat (PipeLatency + 10) @(posedge clk);
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
